[rtl/core/rsa_pkg.sv]
// Package for the running statistics accumulator.
// Holds widths, opcode and status codes, and the beat and queue entry types.
// No dependencies.
`timescale 1ns / 1ps
package rsa_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int SUM_BITS    = 32;
	localparam int SQ_BITS     = 48;
	localparam int ERR_BITS    = 16;
	localparam int DEV_BITS    = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_MERGE  = 3'd3;
	localparam logic [2:0] OP_REPORT = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_LIMIT  = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = 1'd1;

	typedef enum logic [2:0] {
		K_CLEAR,
		K_ADD,
		K_DELETE,
		K_MERGE,
		K_REPORT,
		K_NOP
	} kind_t;

	typedef struct packed {
		logic        [2:0]             opcode;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic signed [SUM_BITS-1:0]    part_sum;
		logic signed [SQ_BITS-1:0]     part_sum_squares;
		logic        [COUNT_BITS-1:0]  part_count;
		logic signed [SAMPLE_BITS-1:0] part_min;
		logic signed [SAMPLE_BITS-1:0] part_max;
	} in_item_t;

	typedef struct packed {
		logic        [1:0]             status;
		logic        [ERR_BITS-1:0]    error_count;
		logic signed [SUM_BITS-1:0]    total;
		logic signed [SQ_BITS-1:0]     total_squares;
		logic        [COUNT_BITS-1:0]  sample_count;
		logic signed [SAMPLE_BITS-1:0] minimum;
		logic signed [SAMPLE_BITS-1:0] maximum;
		logic        [DEV_BITS-1:0]    deviation;
	} out_item_t;

	typedef struct packed {
		kind_t    kind;
		in_item_t item;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

[rtl/core/running_statistics_accumulator_unit.sv]
// Running statistics accumulator, top level: front end, queue, back end, limits.
// Clear, add, delete, merge, unused opcodes, and report with count of one or less: one
// beat per cycle while the output is free, passing the queue and the output register.
// Report with count above one: serial divider (two 64-step divisions), 24-step square
// root; a negative variance term skips the rest. The 4-entry queue accepts until full.
// Reset (arst_n, asynchronous) empties the queue, clears the totals and sets the limits.
`timescale 1ns / 1ps
module running_statistics_accumulator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsa_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rsa_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [rsa_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [rsa_pkg::SAMPLE_BITS-1:0]  cfg_data
);

	logic signed [rsa_pkg::SAMPLE_BITS-1:0] low_limit_q;
	logic signed [rsa_pkg::SAMPLE_BITS-1:0] high_limit_q;
	rsa_pkg::queue_status_t qstat;
	rsa_pkg::entry_t        push_entry;
	rsa_pkg::entry_t        head;
	logic                   push;
	logic                   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= {1'b1, {(rsa_pkg::SAMPLE_BITS-1){1'b0}}};
			high_limit_q <= {1'b0, {(rsa_pkg::SAMPLE_BITS-1){1'b1}}};
		end else if (cfg_we) begin
			case (cfg_index)
				rsa_pkg::REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				rsa_pkg::REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsa_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	rsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	rsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

[rtl/core/rsa_front.sv]
// Front end of the accumulator: accepts input beats and classifies the opcode.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  rsa_pkg::in_item_t  in_data,
	input  rsa_pkg::queue_status_t qstat,
	output logic               push,
	output rsa_pkg::entry_t    push_entry
);

	rsa_pkg::kind_t kind;

	always_comb begin
		case (in_data.opcode)
			rsa_pkg::OP_CLEAR:  kind = rsa_pkg::K_CLEAR;
			rsa_pkg::OP_ADD:    kind = rsa_pkg::K_ADD;
			rsa_pkg::OP_DELETE: kind = rsa_pkg::K_DELETE;
			rsa_pkg::OP_MERGE:  kind = rsa_pkg::K_MERGE;
			rsa_pkg::OP_REPORT: kind = rsa_pkg::K_REPORT;
			default:            kind = rsa_pkg::K_NOP;
		endcase
	end

	assign in_ready        = !qstat.full;
	assign push            = in_valid && !qstat.full;
	assign push_entry.kind = kind;
	assign push_entry.item = in_data;

endmodule

[rtl/core/rsa_queue.sv]
// Short queue between the front and back ends of the accumulator.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rsa_pkg::entry_t        push_entry,
	input  logic                   pop,
	output rsa_pkg::entry_t        head,
	output rsa_pkg::queue_status_t qstat
);

	rsa_pkg::entry_t              mem_q [rsa_pkg::QUEUE_DEPTH];
	logic [rsa_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [rsa_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [rsa_pkg::QPTR_BITS:0]   fill_q;

	assign qstat.empty = (fill_q == '0);
	assign qstat.full  = (fill_q == (rsa_pkg::QPTR_BITS+1)'(rsa_pkg::QUEUE_DEPTH));
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/rsa_back.sv]
// Back end of the accumulator: updates the totals, runs the report sequence through
// a serial divider, used twice, and a square root; holds the output register.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsa_pkg::entry_t                head,
	input  rsa_pkg::queue_status_t         qstat,
	output logic                           pop,
	input  logic signed [rsa_pkg::SAMPLE_BITS-1:0] low_limit,
	input  logic signed [rsa_pkg::SAMPLE_BITS-1:0] high_limit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rsa_pkg::out_item_t             out_data
);

	localparam int SB = rsa_pkg::SAMPLE_BITS;
	localparam int CB = rsa_pkg::COUNT_BITS;
	localparam int QB = rsa_pkg::SQ_BITS;
	localparam int UB = rsa_pkg::SUM_BITS;
	localparam int EB = rsa_pkg::ERR_BITS;
	localparam int DB = rsa_pkg::DEV_BITS;
	localparam int WB = 2 * UB;
	localparam int IB = $clog2(WB);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_SUB,
		S_SQRT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic signed [UB-1:0]   sum_q;
	logic signed [QB-1:0]   sq_q;
	logic        [CB-1:0]   cnt_q;
	logic signed [SB-1:0]   min_q;
	logic signed [SB-1:0]   max_q;
	logic        [EB-1:0]   err_q;
	logic                   out_valid_q;
	rsa_pkg::out_item_t     out_q;

	logic signed [WB-1:0]   prod_q;
	logic        [WB-1:0]   dvd_q;
	logic        [CB-1:0]   rem_q;
	logic        [CB-1:0]   dsr_q;
	logic        [IB-1:0]   it_q;
	logic                   second_q;
	logic        [QB-1:0]   v_q;
	logic        [QB-1:0]   res_q;
	logic        [QB-1:0]   bit_q;
	logic        [DB-1:0]   dev_q;

	logic                   out_free;
	logic                   out_load;
	logic                   go;
	logic signed [SB-1:0]   s;
	logic signed [2*SB-1:0] s_sq;
	logic signed [QB-1:0]   s_sq_ext;
	logic        [CB:0]     merge_cnt;
	logic        [1:0]      status;
	logic signed [UB-1:0]   n_sum;
	logic signed [QB-1:0]   n_sq;
	logic        [CB-1:0]   n_cnt;
	logic signed [SB-1:0]   n_min;
	logic signed [SB-1:0]   n_max;
	logic        [EB-1:0]   n_err;
	logic                   start_rep;
	logic        [CB:0]     rem_sh;
	logic                   ge;
	logic        [CB:0]     rem_sub;
	logic        [WB-1:0]   dvd_nxt;
	logic signed [WB-1:0]   diff;
	logic        [QB-1:0]   trial;

	assign out_free = !out_valid_q || out_ready;
	assign go       = (state_q == S_IDLE) && !qstat.empty && out_free;
	assign pop      = go;
	assign out_load = (go && !start_rep) || ((state_q == S_DONE) && out_free);
	assign s        = head.item.sample;
	assign s_sq     = s * s;
	assign s_sq_ext = QB'(s_sq);
	assign merge_cnt = {1'b0, cnt_q} + {1'b0, head.item.part_count};

	always_comb begin
		status    = rsa_pkg::ST_OK;
		n_sum     = sum_q;
		n_sq      = sq_q;
		n_cnt     = cnt_q;
		n_min     = min_q;
		n_max     = max_q;
		n_err     = err_q;
		start_rep = 1'b0;
		case (head.kind)
			rsa_pkg::K_CLEAR: begin
				n_sum = '0;
				n_sq  = '0;
				n_cnt = '0;
				n_min = {1'b0, {(SB-1){1'b1}}};
				n_max = {1'b1, {(SB-1){1'b0}}};
				n_err = '0;
			end
			rsa_pkg::K_ADD: begin
				if (cnt_q == {CB{1'b1}}) begin
					status = rsa_pkg::ST_REJECT;
				end else begin
					n_sum = sum_q + UB'(s);
					n_sq  = sq_q + s_sq_ext;
					n_cnt = cnt_q + 1'b1;
					if (s > max_q) begin
						n_max = s;
					end
					if (s < min_q) begin
						n_min = s;
					end
					if (s < low_limit || high_limit < s) begin
						status = rsa_pkg::ST_LIMIT;
						if (err_q != {EB{1'b1}}) begin
							n_err = err_q + 1'b1;
						end
					end
				end
			end
			rsa_pkg::K_DELETE: begin
				if (cnt_q == '0) begin
					status = rsa_pkg::ST_REJECT;
				end else begin
					n_sum = sum_q - UB'(s);
					n_sq  = sq_q - s_sq_ext;
					n_cnt = cnt_q - 1'b1;
				end
			end
			rsa_pkg::K_MERGE: begin
				if (merge_cnt[CB]) begin
					status = rsa_pkg::ST_REJECT;
				end else begin
					n_sum = sum_q + head.item.part_sum;
					n_sq  = sq_q + head.item.part_sum_squares;
					n_cnt = merge_cnt[CB-1:0];
					if (head.item.part_max > max_q) begin
						n_max = head.item.part_max;
					end
					if (head.item.part_min < min_q) begin
						n_min = head.item.part_min;
					end
				end
			end
			rsa_pkg::K_REPORT: begin
				start_rep = (cnt_q > CB'(1));
			end
			default: begin
			end
		endcase
	end

	assign rem_sh  = {rem_q, dvd_q[WB-1]};
	assign ge      = (rem_sh >= {1'b0, dsr_q});
	assign rem_sub = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	assign dvd_nxt = {dvd_q[WB-2:0], ge};
	assign diff    = WB'(sq_q) - $signed(dvd_q);
	assign trial   = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			min_q       <= {1'b0, {(SB-1){1'b1}}};
			max_q       <= {1'b1, {(SB-1){1'b0}}};
			err_q       <= '0;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
			it_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (go) begin
						if (start_rep) begin
							state_q <= S_MUL;
						end else begin
							sum_q <= n_sum;
							sq_q  <= n_sq;
							cnt_q <= n_cnt;
							min_q <= n_min;
							max_q <= n_max;
							err_q <= n_err;
							out_q.status        <= status;
							out_q.error_count   <= n_err;
							out_q.total         <= n_sum;
							out_q.total_squares <= n_sq;
							out_q.sample_count  <= n_cnt;
							out_q.minimum       <= n_min;
							out_q.maximum       <= n_max;
							out_q.deviation     <= '0;
						end
					end
				end
				S_MUL: begin
					prod_q   <= sum_q * sum_q;
					state_q  <= S_SUB;
					second_q <= 1'b0;
				end
				S_SUB: begin
					rem_q <= '0;
					it_q  <= '0;
					if (!second_q) begin
						dvd_q   <= prod_q;
						dsr_q   <= cnt_q;
						state_q <= S_DIV;
					end else if (diff[WB-1]) begin
						dev_q   <= '0;
						state_q <= S_DONE;
					end else begin
						dvd_q   <= diff;
						dsr_q   <= cnt_q - 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_sub[CB-1:0];
					dvd_q <= dvd_nxt;
					it_q  <= it_q + 1'b1;
					if (it_q == {IB{1'b1}}) begin
						if (!second_q) begin
							second_q <= 1'b1;
							state_q  <= S_SUB;
						end else begin
							v_q     <= dvd_nxt[QB-1:0];
							res_q   <= '0;
							bit_q   <= QB'(1) << (QB - 2);
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (v_q >= trial) begin
						v_q   <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == QB'(1)) begin
						if (v_q >= trial) begin
							dev_q <= (|(((res_q >> 1) + bit_q) >> DB)) ? {DB{1'b1}}
								: DB'((res_q >> 1) + bit_q);
						end else begin
							dev_q <= (|((res_q >> 1) >> DB)) ? {DB{1'b1}} : DB'(res_q >> 1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.status        <= rsa_pkg::ST_OK;
						out_q.error_count   <= err_q;
						out_q.total         <= sum_q;
						out_q.total_squares <= sq_q;
						out_q.sample_count  <= cnt_q;
						out_q.minimum       <= min_q;
						out_q.maximum       <= max_q;
						out_q.deviation     <= dev_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/core/rsa_checker.sv]
// Port-level checker for the running statistics accumulator, with its bind.
// Depends on rsa_pkg and running_statistics_accumulator_unit.
`timescale 1ns / 1ps
module rsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input rsa_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result beat changed");

	a_dev_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.deviation != '0 |-> out_data.sample_count > 16'd1)
		else $error("deviation reported with fewer than two samples");

	a_limit_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == rsa_pkg::ST_LIMIT |-> out_data.error_count != '0)
		else $error("out-of-limit status with an empty error count");

endmodule

bind running_statistics_accumulator_unit rsa_checker u_rsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
